@@ hdl/pvkt_pkg.sv @@
`timescale 1ns / 1ps

package pvkt_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned MUL_W  = 33;
	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned GAIN_W = 17;
	localparam int unsigned IDX_W  = 3;

	localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

	typedef enum logic [IDX_W-1:0] {
		REG_TIME_STEP     = 3'd0,
		REG_ACCEL_INPUT   = 3'd1,
		REG_NOISE_VAR_POS = 3'd2,
		REG_NOISE_VAR_VEL = 3'd3,
		REG_START_POS     = 3'd4,
		REG_START_VEL     = 3'd5,
		REG_START_VAR_POS = 3'd6,
		REG_START_VAR_VEL = 3'd7
	} reg_idx_t;

	localparam logic [DATA_W-1:0] RST_TIME_STEP     = 32'd65536;
	localparam logic [DATA_W-1:0] RST_ACCEL_INPUT   = 32'd131072;
	localparam logic [DATA_W-1:0] RST_NOISE_VAR_POS = 32'd40960000;
	localparam logic [DATA_W-1:0] RST_NOISE_VAR_VEL = 32'd2359296;
	localparam logic [DATA_W-1:0] RST_START_POS     = 32'd262144000;
	localparam logic [DATA_W-1:0] RST_START_VEL     = 32'd18350080;
	localparam logic [DATA_W-1:0] RST_START_VAR_POS = 32'd26214400;
	localparam logic [DATA_W-1:0] RST_START_VAR_VEL = 32'd1638400;

	localparam logic signed [PROD_W-1:0] S32_MAX = 66'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN = -66'sd2147483648;

	function automatic logic [DATA_W-1:0] sat_s32(input logic signed [PROD_W-1:0] x);
		if (x > S32_MAX) begin
			return 32'h7fff_ffff;
		end else if (x < S32_MIN) begin
			return 32'h8000_0000;
		end else begin
			return x[DATA_W-1:0];
		end
	endfunction

	function automatic logic [DATA_W-1:0] sat_u32(input logic [PROD_W-1:0] x);
		if (|x[PROD_W-1:DATA_W]) begin
			return '1;
		end else begin
			return x[DATA_W-1:0];
		end
	endfunction

endpackage

@@ hdl/pvkt_meas_if.sv @@
`timescale 1ns / 1ps

interface pvkt_meas_if;
	logic        valid;
	logic        ready;
	logic [31:0] meas_pos;
	logic [31:0] meas_vel;
	logic        restart;

	modport source (output valid, meas_pos, meas_vel, restart, input ready);
	modport sink (input valid, meas_pos, meas_vel, restart, output ready);
endinterface

@@ hdl/pvkt_est_if.sv @@
`timescale 1ns / 1ps

interface pvkt_est_if;
	logic        valid;
	logic        ready;
	logic [31:0] est_pos;
	logic [31:0] est_vel;
	logic [31:0] var_pos_out;
	logic [31:0] var_vel_out;

	modport source (output valid, est_pos, est_vel, var_pos_out, var_vel_out, input ready);
	modport sink (input valid, est_pos, est_vel, var_pos_out, var_vel_out, output ready);
endinterface

@@ hdl/pos_vel_kalman_tracker.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// meas      in   valid/ready    meas_pos s32, meas_vel s32, restart 1
// est       out  valid/ready    est_pos s32, est_vel s32, var_pos_out u32, var_vel_out u32
// cfg       in   cfg_we         cfg_index 3, cfg_data 32
//
// a beat on meas is worked through the sequencer states before est goes valid; no new meas
// beat is taken while an update runs. The sequencer uses one 33x33 multiplier nine times and a 17-step restoring
// divider used for both gains
// arst_n clears control and loads the default registers and the start state
// a stalled est beat holds the finished update; meas is taken again once the
// sequencer is back in idle, and the next result waits for est to drain

module pos_vel_kalman_tracker (
	input  logic                  clk,
	input  logic                  arst_n,
	pvkt_meas_if.sink             meas,
	pvkt_est_if.source            est,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DV,
		S_DP1,
		S_DP2,
		S_PRED,
		S_DT2,
		S_VPPM,
		S_VPP,
		S_DIV_LOAD,
		S_DIV_RUN,
		S_CP,
		S_CV,
		S_VP,
		S_VV,
		S_DONE
	} state_t;

	localparam logic [4:0] DIV_LAST = 5'd16;

	state_t state_q;

	logic [31:0] time_step_q, accel_q, nvp_q, nvv_q;
	logic [31:0] start_pos_q, start_vel_q, start_vp_q, start_vv_q;

	logic [31:0] pos_q, vel_q, vp_q, vv_q;

	logic [31:0] mp_q, mv_q;
	logic [31:0] dv_q, dp1_q, pp_q, pv_q, dt2_q, vpp_q;
	logic [31:0] estp_q, estv_q, varp_q;
	logic [16:0] kp_q, kv_q;

	logic [32:0] den_q, rem_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        sel_q;

	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic               mul_en;

	logic [31:0] out_pos_q, out_vel_q, out_vp_q, out_vv_q;
	logic        est_valid_q;

	logic        in_fire, out_free;
	logic [31:0] dp2;
	logic signed [33:0] pp_sum;
	logic signed [33:0] pv_sum;
	logic [31:0] pp_sat, pv_sat;
	logic [32:0] vpp_sum;
	logic [31:0] vpp_sat;
	logic signed [65:0] est_sum;
	logic [31:0] est_sat;
	logic [31:0] div_var, div_r;
	logic        div_nbit;
	logic [33:0] rem_sh;
	logic        div_ge;
	logic [33:0] rem_sub;
	logic [16:0] quot_next, k_fin;
	logic signed [32:0] innov_p, innov_v;

	assign meas.ready      = (state_q == S_IDLE);
	assign in_fire         = meas.valid && meas.ready;
	assign out_free        = !est_valid_q || est.ready;
	assign est.valid       = est_valid_q;
	assign est.est_pos     = out_pos_q;
	assign est.est_vel     = out_vel_q;
	assign est.var_pos_out = out_vp_q;
	assign est.var_vel_out = out_vv_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= pvkt_pkg::RST_TIME_STEP;
			accel_q     <= pvkt_pkg::RST_ACCEL_INPUT;
			nvp_q       <= pvkt_pkg::RST_NOISE_VAR_POS;
			nvv_q       <= pvkt_pkg::RST_NOISE_VAR_VEL;
			start_pos_q <= pvkt_pkg::RST_START_POS;
			start_vel_q <= pvkt_pkg::RST_START_VEL;
			start_vp_q  <= pvkt_pkg::RST_START_VAR_POS;
			start_vv_q  <= pvkt_pkg::RST_START_VAR_VEL;
		end else if (cfg_we) begin
			case (pvkt_pkg::reg_idx_t'(cfg_index))
				pvkt_pkg::REG_TIME_STEP:     time_step_q <= cfg_data;
				pvkt_pkg::REG_ACCEL_INPUT:   accel_q     <= cfg_data;
				pvkt_pkg::REG_NOISE_VAR_POS: nvp_q       <= cfg_data;
				pvkt_pkg::REG_NOISE_VAR_VEL: nvv_q       <= cfg_data;
				pvkt_pkg::REG_START_POS:     start_pos_q <= cfg_data;
				pvkt_pkg::REG_START_VEL:     start_vel_q <= cfg_data;
				pvkt_pkg::REG_START_VAR_POS: start_vp_q  <= cfg_data;
				pvkt_pkg::REG_START_VAR_VEL: start_vv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared multiplier operands
	always_comb begin
		innov_p = $signed({mp_q[31], mp_q}) - $signed({pp_q[31], pp_q});
		innov_v = $signed({mv_q[31], mv_q}) - $signed({pv_q[31], pv_q});
		mul_a   = '0;
		mul_b   = '0;
		mul_en  = 1'b1;
		case (state_q)
			S_DV: begin
				mul_a = $signed({1'b0, time_step_q});
				mul_b = $signed({accel_q[31], accel_q});
			end
			S_DP1: begin
				mul_a = $signed({1'b0, time_step_q});
				mul_b = $signed({vel_q[31], vel_q});
			end
			S_DP2: begin
				mul_a = $signed({1'b0, time_step_q});
				mul_b = $signed({dv_q[31], dv_q});
			end
			S_PRED: begin
				mul_a = $signed({1'b0, time_step_q});
				mul_b = $signed({1'b0, time_step_q});
			end
			S_VPPM: begin
				mul_a = $signed({1'b0, dt2_q});
				mul_b = $signed({1'b0, vv_q});
			end
			S_CP: begin
				mul_a = $signed({16'd0, kp_q});
				mul_b = innov_p;
			end
			S_CV: begin
				mul_a = $signed({16'd0, kv_q});
				mul_b = innov_v;
			end
			S_VP: begin
				mul_a = $signed({16'd0, pvkt_pkg::ONE_Q16 - kp_q});
				mul_b = $signed({1'b0, vpp_q});
			end
			S_VV: begin
				mul_a = $signed({16'd0, pvkt_pkg::ONE_Q16 - kv_q});
				mul_b = $signed({1'b0, vv_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// prediction sums, divider step, correction sum
	always_comb begin
		dp2     = pvkt_pkg::sat_s32(prod_q >>> 17);
		pp_sum  = $signed({{2{pos_q[31]}}, pos_q}) + $signed({{2{dp1_q[31]}}, dp1_q})
			+ $signed({{2{dp2[31]}}, dp2});
		pv_sum  = $signed({{2{vel_q[31]}}, vel_q}) + $signed({{2{dv_q[31]}}, dv_q});
		pp_sat  = pvkt_pkg::sat_s32($signed({{32{pp_sum[33]}}, pp_sum}));
		pv_sat  = pvkt_pkg::sat_s32($signed({{32{pv_sum[33]}}, pv_sum}));
		vpp_sum = {1'b0, vp_q} + {1'b0, pvkt_pkg::sat_u32(prod_q >>> 16)};
		vpp_sat = vpp_sum[32] ? '1 : vpp_sum[31:0];

		div_var   = sel_q ? vv_q : vpp_q;
		div_r     = sel_q ? nvv_q : nvp_q;
		div_nbit  = (cnt_q == DIV_LAST) ? div_var[0] : 1'b0;
		rem_sh    = {rem_q, div_nbit};
		div_ge    = rem_sh >= {1'b0, den_q};
		rem_sub   = rem_sh - {1'b0, den_q};
		quot_next = {quot_q[15:0], div_ge};
		k_fin     = (den_q == '0) ? '0 : quot_next;

		if (state_q == S_CV) begin
			est_sum = $signed({{34{pp_q[31]}}, pp_q}) + (prod_q >>> 16);
		end else begin
			est_sum = $signed({{34{pv_q[31]}}, pv_q}) + (prod_q >>> 16);
		end
		est_sat = pvkt_pkg::sat_s32(est_sum);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					mp_q <= meas.meas_pos;
					mv_q <= meas.meas_vel;
				end
			end
			S_DP1: dv_q <= pvkt_pkg::sat_s32(prod_q >>> 16);
			S_DP2: dp1_q <= pvkt_pkg::sat_s32(prod_q >>> 16);
			S_PRED: begin
				pp_q <= pp_sat;
				pv_q <= pv_sat;
			end
			S_DT2: dt2_q <= pvkt_pkg::sat_u32(prod_q >>> 16);
			S_VPP: vpp_q <= vpp_sat;
			S_DIV_LOAD: begin
				den_q  <= {1'b0, div_var} + {1'b0, div_r};
				rem_q  <= {2'b00, div_var[31:1]};
				quot_q <= '0;
			end
			S_DIV_RUN: begin
				rem_q  <= div_ge ? rem_sub[32:0] : rem_sh[32:0];
				quot_q <= quot_next;
				if (cnt_q == '0) begin
					if (sel_q) begin
						kv_q <= k_fin;
					end else begin
						kp_q <= k_fin;
					end
				end
			end
			S_CV: estp_q <= est_sat;
			S_VP: estv_q <= est_sat;
			S_VV: varp_q <= prod_q[47:16];
			S_DONE: begin
				if (out_free) begin
					out_pos_q <= estp_q;
					out_vel_q <= estv_q;
					out_vp_q  <= varp_q;
					out_vv_q  <= prod_q[47:16];
				end
			end
			default: ;
		endcase
	end

	// sequencer, filter state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			est_valid_q <= 1'b0;
			pos_q       <= pvkt_pkg::RST_START_POS;
			vel_q       <= pvkt_pkg::RST_START_VEL;
			vp_q        <= pvkt_pkg::RST_START_VAR_POS;
			vv_q        <= pvkt_pkg::RST_START_VAR_VEL;
		end else begin
			if (est.ready && !(state_q == S_DONE && out_free)) begin
				est_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (meas.restart) begin
							pos_q <= start_pos_q;
							vel_q <= start_vel_q;
							vp_q  <= start_vp_q;
							vv_q  <= start_vv_q;
						end
						state_q <= S_DV;
					end
				end
				S_DV:   state_q <= S_DP1;
				S_DP1:  state_q <= S_DP2;
				S_DP2:  state_q <= S_PRED;
				S_PRED: state_q <= S_DT2;
				S_DT2:  state_q <= S_VPPM;
				S_VPPM: state_q <= S_VPP;
				S_VPP: begin
					sel_q   <= 1'b0;
					state_q <= S_DIV_LOAD;
				end
				S_DIV_LOAD: begin
					cnt_q   <= DIV_LAST;
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (cnt_q == '0) begin
						if (sel_q) begin
							state_q <= S_CP;
						end else begin
							sel_q   <= 1'b1;
							state_q <= S_DIV_LOAD;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_CP: state_q <= S_CV;
				S_CV: state_q <= S_VP;
				S_VP: state_q <= S_VV;
				S_VV: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						pos_q       <= estp_q;
						vel_q       <= estv_q;
						vp_q        <= varp_q;
						vv_q        <= prod_q[47:16];
						est_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/pvkt_checker.sv @@
`timescale 1ns / 1ps

module pvkt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] est_pos,
	input logic [31:0] est_vel,
	input logic [31:0] var_pos_out,
	input logic [31:0] var_vel_out
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("est beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(est_pos) && $stable(est_vel)
			&& $stable(var_pos_out) && $stable(var_vel_out))
		else $error("est payload changed while stalled");

	// one update at a time
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("meas taken again while an update runs");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a meas beat");

	// a result is posted as the sequencer returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result posted while still busy");

endmodule

bind pos_vel_kalman_tracker pvkt_checker u_pvkt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (meas.valid),
	.in_ready    (meas.ready),
	.out_valid   (est.valid),
	.out_ready   (est.ready),
	.est_pos     (est.est_pos),
	.est_vel     (est.est_vel),
	.var_pos_out (est.var_pos_out),
	.var_vel_out (est.var_vel_out)
);

@@ tb/tb_pos_vel_kalman_tracker.sv @@
`timescale 1ns / 1ps

module tb_pos_vel_kalman_tracker;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned RAND_PHASES = 14;
	localparam int unsigned PHASE_ITEMS = 64;

	typedef struct packed {
		logic [31:0] est_pos;
		logic [31:0] est_vel;
		logic [31:0] var_pos_out;
		logic [31:0] var_vel_out;
	} est_beat_t;

	class kalman_scoreboard;
		logic [31:0] regs [8];
		longint pos_est, vel_est;
		longint unsigned pos_var, vel_var;
		est_beat_t est_q[$];
		int unsigned fail_count;

		function new();
			regs[pvkt_pkg::REG_TIME_STEP]     = pvkt_pkg::RST_TIME_STEP;
			regs[pvkt_pkg::REG_ACCEL_INPUT]   = pvkt_pkg::RST_ACCEL_INPUT;
			regs[pvkt_pkg::REG_NOISE_VAR_POS] = pvkt_pkg::RST_NOISE_VAR_POS;
			regs[pvkt_pkg::REG_NOISE_VAR_VEL] = pvkt_pkg::RST_NOISE_VAR_VEL;
			regs[pvkt_pkg::REG_START_POS]     = pvkt_pkg::RST_START_POS;
			regs[pvkt_pkg::REG_START_VEL]     = pvkt_pkg::RST_START_VEL;
			regs[pvkt_pkg::REG_START_VAR_POS] = pvkt_pkg::RST_START_VAR_POS;
			regs[pvkt_pkg::REG_START_VAR_VEL] = pvkt_pkg::RST_START_VAR_VEL;
			fail_count = 0;
			reload_start();
		endfunction

		function void reload_start();
			pos_est = $signed(regs[pvkt_pkg::REG_START_POS]);
			vel_est = $signed(regs[pvkt_pkg::REG_START_VEL]);
			pos_var = regs[pvkt_pkg::REG_START_VAR_POS];
			vel_var = regs[pvkt_pkg::REG_START_VAR_VEL];
		endfunction

		function void set_reg(pvkt_pkg::reg_idx_t idx, logic [31:0] data);
			regs[idx] = data;
		endfunction

		function longint clamp_s32(longint x);
			if (x > 64'sd2147483647) begin
				return 64'sd2147483647;
			end else if (x < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return x;
		endfunction

		function longint unsigned clamp_u32(longint unsigned x);
			return (x > 64'hffff_ffff) ? 64'hffff_ffff : x;
		endfunction

		function longint unsigned gain_q16(longint unsigned v, longint unsigned r);
			longint unsigned den;
			den = v + r;
			if (den == 0) begin
				return 0;
			end
			return (v << 16) / den;
		endfunction

		function longint pull_toward(longint pred, longint meas, longint unsigned k);
			longint ks, innov;
			ks = k;
			innov = meas - pred;
			return clamp_s32(pred + ((ks * innov) >>> 16));
		endfunction

		// one measurement beat: predict with the control input, then correct per axis
		function void note_meas(logic [31:0] mp_raw, logic [31:0] mv_raw, logic restart);
			longint mp, mv, dt, acc, dv, dp1, dp2, pp, pv;
			longint unsigned dtu, dt2, vpp, vvp, kp, kv;
			est_beat_t e;
			mp = $signed(mp_raw);
			mv = $signed(mv_raw);
			dtu = regs[pvkt_pkg::REG_TIME_STEP];
			dt = dtu;
			acc = $signed(regs[pvkt_pkg::REG_ACCEL_INPUT]);
			if (restart) begin
				reload_start();
			end
			dv = clamp_s32((dt * acc) >>> 16);
			dp1 = clamp_s32((dt * vel_est) >>> 16);
			dp2 = clamp_s32((dt * dv) >>> 17);
			pp = clamp_s32(pos_est + dp1 + dp2);
			pv = clamp_s32(vel_est + dv);
			dt2 = clamp_u32((dtu * dtu) >> 16);
			vpp = clamp_u32(pos_var + clamp_u32((dt2 * vel_var) >> 16));
			vvp = vel_var;
			kp = gain_q16(vpp, regs[pvkt_pkg::REG_NOISE_VAR_POS]);
			kv = gain_q16(vvp, regs[pvkt_pkg::REG_NOISE_VAR_VEL]);
			pos_est = pull_toward(pp, mp, kp);
			vel_est = pull_toward(pv, mv, kv);
			pos_var = clamp_u32(((64'd65536 - kp) * vpp) >> 16);
			vel_var = clamp_u32(((64'd65536 - kv) * vvp) >> 16);
			e.est_pos = pos_est[31:0];
			e.est_vel = vel_est[31:0];
			e.var_pos_out = pos_var[31:0];
			e.var_vel_out = vel_var[31:0];
			est_q.push_back(e);
		endfunction

		function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
				fail_count++;
			end
		endfunction

		function void check_est(est_beat_t got);
			est_beat_t e;
			if (est_q.size() == 0) begin
				$error("est beat with no prediction pending: %h", got);
				fail_count++;
				return;
			end
			e = est_q.pop_front();
			cmp_field("est_pos", e.est_pos, got.est_pos);
			cmp_field("est_vel", e.est_vel, got.est_vel);
			cmp_field("var_pos_out", e.var_pos_out, got.var_pos_out);
			cmp_field("var_vel_out", e.var_vel_out, got.var_vel_out);
		endfunction

		function int pending();
			return est_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	pvkt_meas_if meas_ch ();
	pvkt_est_if est_ch ();

	pos_vel_kalman_tracker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas_ch),
		.est       (est_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kalman_scoreboard sb;
	logic [31:0] cfg_set [8];
	int unsigned burst_left;
	int unsigned stall_mode, mode_left, stall_left;

	always #2 clk = ~clk;

	// receiver: the stall mode is redrawn each time its countdown runs out
	always @(posedge clk) begin
		if (!arst_n) begin
			est_ch.ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 200;
			stall_left <= 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(64, 512);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: est_ch.ready <= 1'b1;
				1: est_ch.ready <= 1'($urandom_range(0, 1));
				2: est_ch.ready <= ($urandom_range(0, 3) == 0);
				default: begin
					if (stall_left == 0) begin
						est_ch.ready <= 1'b1;
						stall_left <= $urandom_range(5, 60);
					end else begin
						est_ch.ready <= 1'b0;
						stall_left <= stall_left - 1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && est_ch.valid && est_ch.ready) begin
			sb.check_est({est_ch.est_pos, est_ch.est_vel, est_ch.var_pos_out,
				est_ch.var_vel_out});
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	task automatic send_meas(input logic [31:0] p, input logic [31:0] v, input logic r);
		meas_ch.valid <= 1'b1;
		meas_ch.meas_pos <= p;
		meas_ch.meas_vel <= v;
		meas_ch.restart <= r;
		@(posedge clk);
		while (!meas_ch.ready) @(posedge clk);
		sb.note_meas(p, v, r);
		if (burst_left == 0) begin
			meas_ch.valid <= 1'b0;
			burst_left = $urandom_range(0, 12);
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic settle();
		meas_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic apply_config();
		pvkt_pkg::reg_idx_t idx;
		idx = idx.first();
		do begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= cfg_set[idx];
			sb.set_reg(idx, cfg_set[idx]);
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] odd_word();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom();
		endcase
	endfunction

	function automatic void rand_config(bit wild);
		cfg_set[pvkt_pkg::REG_TIME_STEP]     = $urandom_range(32'h1000, 32'h4_0000);
		cfg_set[pvkt_pkg::REG_ACCEL_INPUT]   = $urandom_range(0, 20 << 16) - (10 << 16);
		cfg_set[pvkt_pkg::REG_NOISE_VAR_POS] = $urandom_range(1 << 14, 1000 << 16);
		cfg_set[pvkt_pkg::REG_NOISE_VAR_VEL] = $urandom_range(1 << 14, 100 << 16);
		cfg_set[pvkt_pkg::REG_START_POS]     = $urandom_range(0, 10000 << 16) - (5000 << 16);
		cfg_set[pvkt_pkg::REG_START_VEL]     = $urandom_range(0, 1000 << 16) - (500 << 16);
		cfg_set[pvkt_pkg::REG_START_VAR_POS] = $urandom_range(0, 1000 << 16);
		cfg_set[pvkt_pkg::REG_START_VAR_VEL] = $urandom_range(0, 100 << 16);
		if (wild) begin
			foreach (cfg_set[i]) begin
				if ($urandom_range(0, 1) == 0) begin
					cfg_set[i] = odd_word();
				end
			end
		end
	endfunction

	initial begin
		logic [31:0] p, v;
		bit r, wild;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pvkt_pkg::REG_TIME_STEP;
		cfg_data = '0;
		meas_ch.valid = 1'b0;
		meas_ch.meas_pos = '0;
		meas_ch.meas_vel = '0;
		meas_ch.restart = 1'b0;
		sb = new();
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults
		send_meas(32'd262799360, 32'd18415616, 1'b0);
		send_meas(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_meas(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_meas(32'h0000_0000, 32'h0000_0000, 1'b1);
		send_meas(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		send_meas(32'h8000_0000, 32'h7fff_ffff, 1'b1);
		settle();

		// zero denominator on both axes
		cfg_set[pvkt_pkg::REG_TIME_STEP]     = 32'h0;
		cfg_set[pvkt_pkg::REG_ACCEL_INPUT]   = 32'h0;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_POS] = 32'h0;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_VEL] = 32'h0;
		cfg_set[pvkt_pkg::REG_START_POS]     = 32'h1234_0000;
		cfg_set[pvkt_pkg::REG_START_VEL]     = 32'hffe0_0000;
		cfg_set[pvkt_pkg::REG_START_VAR_POS] = 32'h0;
		cfg_set[pvkt_pkg::REG_START_VAR_VEL] = 32'h0;
		apply_config();
		send_meas(32'h7fff_ffff, 32'h8000_0000, 1'b1);
		send_meas(32'h0001_0000, 32'hffff_0000, 1'b0);
		send_meas($urandom(), $urandom(), 1'b0);
		settle();

		// positive saturation everywhere
		cfg_set[pvkt_pkg::REG_TIME_STEP]     = 32'hffff_ffff;
		cfg_set[pvkt_pkg::REG_ACCEL_INPUT]   = 32'h7fff_ffff;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_POS] = 32'hffff_ffff;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_VEL] = 32'hffff_ffff;
		cfg_set[pvkt_pkg::REG_START_POS]     = 32'h7fff_ffff;
		cfg_set[pvkt_pkg::REG_START_VEL]     = 32'h7fff_ffff;
		cfg_set[pvkt_pkg::REG_START_VAR_POS] = 32'hffff_ffff;
		cfg_set[pvkt_pkg::REG_START_VAR_VEL] = 32'hffff_ffff;
		apply_config();
		send_meas(32'h8000_0000, 32'h8000_0000, 1'b1);
		send_meas(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_meas(32'h0000_0000, 32'h0000_0000, 1'b0);
		settle();

		// negative saturation, full position gain, zero velocity denominator
		cfg_set[pvkt_pkg::REG_ACCEL_INPUT]   = 32'h8000_0000;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_POS] = 32'h0;
		cfg_set[pvkt_pkg::REG_NOISE_VAR_VEL] = 32'h0;
		cfg_set[pvkt_pkg::REG_START_POS]     = 32'h8000_0000;
		cfg_set[pvkt_pkg::REG_START_VEL]     = 32'h8000_0000;
		cfg_set[pvkt_pkg::REG_START_VAR_VEL] = 32'h0;
		apply_config();
		send_meas(32'h7fff_ffff, 32'h0000_0000, 1'b1);
		send_meas(32'h8000_0000, 32'h7fff_ffff, 1'b0);
		send_meas(32'h1234_5678, 32'h9abc_def0, 1'b0);
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wild = ph[0];
			rand_config(wild);
			apply_config();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = (n == 0) || ($urandom_range(0, 15) == 0);
				if (!wild && $urandom_range(0, 4) != 0) begin
					// measurements that follow the track closely
					p = sb.pos_est[31:0] + $urandom_range(0, 100 << 16) - (50 << 16);
					v = sb.vel_est[31:0] + $urandom_range(0, 10 << 16) - (5 << 16);
				end else begin
					p = odd_word();
					v = odd_word();
				end
				send_meas(p, v, r);
			end
			settle();
		end

		repeat (100) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
